/* sv/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the particle depth sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int COORD_W = 16;
  localparam int KEY_W   = 34;
  localparam int IDX_W   = 6;
  localparam int REG_W   = 2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [REG_W-1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      batch_end;
  } in_req_t;

  typedef struct packed {
    idx_t source_index;
    idx_t rank;
    key_t dist_sq;
    logic run_end;
  } out_req_t;

  typedef struct packed {
    logic store;
    idx_t idx;
    logic batch_end;
  } tag_t;

  typedef struct packed {
    key_t key;
    idx_t idx;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   shift;
    entry_t entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/pds_dist.sv */
// ----------------------------------------------------------------------------
// pds_dist
// Three-stage pipeline forming the saturated squared camera distance.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_dist (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  valid_i,
  input  wire pds_pkg::in_req_t                req_i,
  input  wire pds_pkg::tag_t                   tag_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] cam_x_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] cam_y_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] cam_z_i,
  output logic                                 valid_o,
  output pds_pkg::key_t                        key_o,
  output pds_pkg::tag_t                        tag_o
);
  import pds_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;

  logic              s1_valid_q, s2_valid_q, s3_valid_q;
  tag_t              s1_tag_q, s2_tag_q, s3_tag_q;
  logic [DIFF_W-1:0] dx_d, dy_d, dz_d;
  logic [DIFF_W-1:0] mx_q, my_q, mz_q;
  logic [SQ_W-1:0]   sx_q, sy_q, sz_q;
  logic [SUM_W-1:0]  sum;
  key_t              key_d, key_q;

  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  assign dx_d = abs_diff(req_i.pos_x, cam_x_i);
  assign dy_d = abs_diff(req_i.pos_y, cam_y_i);
  assign dz_d = abs_diff(req_i.pos_z, cam_z_i);

  assign sum = SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);

  generate
    if (SUM_W > KEY_W) begin : g_sat
      assign key_d = (|sum[SUM_W-1:KEY_W]) ? {KEY_W{1'b1}} : sum[KEY_W-1:0];
    end else begin : g_nosat
      assign key_d = KEY_W'(sum);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q     <= dx_d;
    my_q     <= dy_d;
    mz_q     <= dz_d;
    s1_tag_q <= tag_i;
    sx_q     <= mx_q * mx_q;
    sy_q     <= my_q * my_q;
    sz_q     <= mz_q * mz_q;
    s2_tag_q <= s1_tag_q;
    key_q    <= key_d;
    s3_tag_q <= s2_tag_q;
  end

  assign valid_o = s3_valid_q;
  assign key_o   = key_q;
  assign tag_o   = s3_tag_q;

endmodule

`default_nettype wire

/* sv/pds_cell.sv */
// ----------------------------------------------------------------------------
// pds_cell
// One slot of the insertion chain, holding one key and its arrival index.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_cell (
  input  wire                  clk_i,
  input  wire                  occupied_i,
  input  wire pds_pkg::cell_ctrl_t ctrl_i,
  input  wire pds_pkg::entry_t prev_entry_i,
  input  wire                  prev_before_i,
  input  wire pds_pkg::entry_t next_entry_i,
  output pds_pkg::entry_t      entry_o,
  output logic                 before_o
);
  import pds_pkg::*;

  entry_t entry_q;

  // The new key goes ahead of this slot when the slot is empty or the new key is strictly larger (farther).
  assign before_o = !occupied_i || (ctrl_i.entry.key > entry_q.key);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= next_entry_i;
    end else if (ctrl_i.insert && before_o) begin
      entry_q <= prev_before_i ? prev_entry_i : ctrl_i.entry;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* sv/particle_depth_sort.sv */
// ----------------------------------------------------------------------------
// particle_depth_sort
// Back-to-front depth sort of a particle batch on a chain of insertion cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   in_req_i  (in_req_t)
//  out       output     out_valid_o / out_ready_i out_req_o (out_req_t)
//  cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// While a batch fills, one request is taken every cycle; each key passes through the
// distance pipeline registers before it enters the cell chain.
// After the request with batch_end is taken, input stalls until every stored
// particle has been shifted out, as the chain shifts one result per cycle.
// Output stalls hold the chain. Reset clears control only; no clearing pass.
`default_nettype none

module particle_depth_sort #(
  parameter int CAPACITY = 64
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire pds_pkg::in_req_t                in_req_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output pds_pkg::out_req_t                    out_req_o,
  input  wire                                  cfg_we_i,
  input  wire logic [pds_pkg::REG_W-1:0]       cfg_index_i,
  input  wire logic [pds_pkg::COORD_W-1:0]     cfg_data_i
);
  import pds_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [CNT_W-1:0]          accept_cnt_q, fill_q;
  logic                      busy_q, drain_q;
  idx_t                      rank_q;
  logic                      out_valid_q;
  out_req_t                  out_q;

  logic       in_fire, load_out, last_out;
  tag_t       tag_in, tag_out;
  logic       dist_valid;
  key_t       dist_key;
  cell_ctrl_t ctrl;
  entry_t     entries [CAPACITY];
  logic       ahead   [CAPACITY];

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  assign tag_in.store     = accept_cnt_q < CNT_W'(CAPACITY);
  assign tag_in.idx       = IDX_W'(accept_cnt_q);
  assign tag_in.batch_end = in_req_i.batch_end;

  pds_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_fire),
    .req_i   (in_req_i),
    .tag_i   (tag_in),
    .cam_x_i (cam_x_q),
    .cam_y_i (cam_y_q),
    .cam_z_i (cam_z_q),
    .valid_o (dist_valid),
    .key_o   (dist_key),
    .tag_o   (tag_out)
  );

  assign load_out = drain_q && (!out_valid_q || out_ready_i);
  assign last_out = rank_q == IDX_W'(fill_q - CNT_W'(1));

  assign ctrl.insert    = dist_valid && tag_out.store;
  assign ctrl.shift     = load_out;
  assign ctrl.entry.key = dist_key;
  assign ctrl.entry.idx = tag_out.idx;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pds_cell u_cell (
      .clk_i         (clk_i),
      .occupied_i    (CNT_W'(i) < fill_q),
      .ctrl_i        (ctrl),
      .prev_entry_i  ((i == 0) ? entries[0] : entries[(i == 0) ? 0 : i - 1]),
      .prev_before_i ((i == 0) ? 1'b0 : ahead[(i == 0) ? 0 : i - 1]),
      .next_entry_i  ((i == CAPACITY - 1) ? '0 :
                      entries[(i == CAPACITY - 1) ? i : i + 1]),
      .entry_o       (entries[i]),
      .before_o      (ahead[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CAMERA_X: cam_x_q <= cfg_data_i;
        REG_CAMERA_Y: cam_y_q <= cfg_data_i;
        REG_CAMERA_Z: cam_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_cnt_q <= '0;
      fill_q       <= '0;
      busy_q       <= 1'b0;
      drain_q      <= 1'b0;
      rank_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_req_i.batch_end) begin
          accept_cnt_q <= '0;
          busy_q       <= 1'b1;
        end else if (tag_in.store) begin
          accept_cnt_q <= accept_cnt_q + CNT_W'(1);
        end
      end
      if (ctrl.insert) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (dist_valid && tag_out.batch_end) begin
        drain_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (last_out) begin
          rank_q  <= '0;
          fill_q  <= '0;
          drain_q <= 1'b0;
          busy_q  <= 1'b0;
        end else begin
          rank_q <= rank_q + IDX_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.source_index <= entries[0].idx;
      out_q.rank         <= rank_q;
      out_q.dist_sq      <= entries[0].key;
      out_q.run_end      <= last_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire
